### hdl/sfm_pkg.sv
// Shared types and constants for the substring first-match search block.
// Used by sfm_match and substring_first_match_core; depends on nothing.

package sfm_pkg;

  // Default sizing of the search
  localparam int          PATTERN_MAX_DEF = 16;
  localparam int unsigned HAY_MAX_DEF     = 32'd65535;

  // Fixed field widths
  localparam int PAT_BYTES = 16;  // bytes held by the two pattern registers
  localparam int LEN_W     = 5;   // pattern length register
  localparam int POS_W     = 17;  // signed start position
  localparam int OFS_W     = 16;  // zero-based start offset
  localparam int IDX_W     = 17;  // one-based match index
  localparam int CFG_AW    = 2;
  localparam int CFG_DW    = 64;

  typedef logic [7:0] byte_t;

  // Configuration register indexes
  typedef enum logic [CFG_AW-1:0] {
    CFG_PAT_LO  = 2'd0,
    CFG_PAT_HI  = 2'd1,
    CFG_PAT_LEN = 2'd2
  } cfg_idx_t;

endpackage

### hdl/sfm_match.sv
// Parallel compare of the haystack window against the configured pattern.
// Depends on sfm_pkg; purely combinational, one lane per pattern byte.

module sfm_match
  import sfm_pkg::*;
#(
  parameter int LANE_N = PAT_BYTES
) (
  input  byte_t              win [LANE_N],    // newest byte at entry 0
  input  byte_t              pat [PAT_BYTES],
  input  logic [LEN_W-1:0]   len,             // already limited to LANE_N
  output logic               hit
);

  localparam int WIN_AW = (LANE_N > 1) ? $clog2(LANE_N) : 1;

  logic [LANE_N-1:0] lane_ok;

  // Pattern byte k lines up with window entry len-1-k; unused lanes pass
  for (genvar k = 0; k < LANE_N; k++) begin : g_lane
    logic [LEN_W-1:0] pos;
    assign pos        = len - LEN_W'(k + 1);
    assign lane_ok[k] = (LEN_W'(k) >= len) || (pat[k] == win[pos[WIN_AW-1:0]]);
  end

  assign hit = &lane_ok;

endmodule

### hdl/substring_first_match_core.sv
// Top level of the substring first-match search block.
// Depends on sfm_pkg and sfm_match.
//
// Usage:
//   Write the pattern (bytes 0..7, bytes 8..15) and its length on the cfg
//   channel while the block is idle; cfg_ready is always high.
//   Stream the haystack on the in_ channel, one byte per transaction.
//   in_first_item starts a new haystack and samples in_start_pos (one-based,
//   values of 1 or below search from the first byte). in_byte_present low
//   sends an item with no byte, so an empty haystack can be sent.
//   The transaction with in_last_item high yields one out_ transaction:
//   out_match_index (one-based, 0 when no match) and out_overflow.
// Timing:
//   One transaction per cycle sustained while no last item is stalled.
//   A transaction is captured in the input register and processed from
//   there; a last item's result goes to the output register, shown from then on.
//   The window compare is a single pass over all pattern lanes in parallel.
// Reset and stall:
//   Synchronous active-low reset clears config, valid, counter and flag registers only.
//   While out_ready is low with a result pending, a last item in the input
//   register waits and in_ready falls; other items keep flowing.

module substring_first_match_core
  import sfm_pkg::*;
#(
  parameter int          PATTERN_MAX = PATTERN_MAX_DEF,
  parameter int unsigned HAY_MAX     = HAY_MAX_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  // haystack items
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [7:0]              in_hay_byte,
  input  logic                    in_byte_present,
  input  logic                    in_first_item,
  input  logic                    in_last_item,
  input  logic signed [POS_W-1:0] in_start_pos,
  // results
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [IDX_W-1:0]        out_match_index,
  output logic                    out_overflow,
  // configuration writes
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [CFG_AW-1:0]       cfg_index,
  input  logic [CFG_DW-1:0]       cfg_data
);

  localparam int LANE_N = (PATTERN_MAX < PAT_BYTES) ? PATTERN_MAX : PAT_BYTES;
  localparam int CNT_W  = $clog2(longint'(HAY_MAX) + 64'd1);
  localparam int CMP_W  = ((CNT_W > OFS_W) ? CNT_W : OFS_W) + 1;

  // Configuration registers
  logic [CFG_DW-1:0] pat_lo_r, pat_hi_r;
  logic [LEN_W-1:0]  pat_len_r;
  byte_t             pat_bytes [PAT_BYTES];
  logic [LEN_W-1:0]  eff_len;

  // Input register
  logic                    ir_vld_r, ir_vld_nxt;
  byte_t                   ir_byte_r;
  logic                    ir_present_r, ir_first_r, ir_last_r;
  logic signed [POS_W-1:0] ir_start_r;

  // Search state
  byte_t             win_r   [LANE_N];
  byte_t             win_nxt [LANE_N];
  logic [CNT_W-1:0]  cnt_r, cnt_nxt, cnt_base;
  logic [OFS_W-1:0]  ofs_r, ofs_nxt, ofs_calc;
  logic              found_r, found_nxt, found_base;
  logic [CNT_W-1:0]  found_idx_r, found_idx_nxt, found_idx_base;
  logic              ovf_r, ovf_nxt, ovf_base;

  // Output register
  logic              out_vld_r, out_vld_nxt;
  logic [IDX_W-1:0]  out_idx_r, out_idx_nxt;
  logic              out_ovf_r, out_ovf_nxt;

  logic              advance, load_out, take, at_lim, hit, match_ok;
  logic [CMP_W-1:0]  empty_idx, res_idx;

  assign cfg_ready = 1'b1;

  // Write configuration registers; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pat_lo_r  <= '0;
      pat_hi_r  <= '0;
      pat_len_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_PAT_LO:  pat_lo_r  <= cfg_data;
        CFG_PAT_HI:  pat_hi_r  <= cfg_data;
        CFG_PAT_LEN: pat_len_r <= cfg_data[LEN_W-1:0];
        default:     ;
      endcase
    end
  end

  // Unpack pattern bytes, byte 0 in the low bits
  for (genvar k = 0; k < PAT_BYTES; k++) begin : g_pat
    if (k < 8) begin : g_lo
      assign pat_bytes[k] = pat_lo_r[8*k +: 8];
    end else begin : g_hi
      assign pat_bytes[k] = pat_hi_r[8*(k-8) +: 8];
    end
  end

  // Saturate the length to the window size
  assign eff_len = (pat_len_r > LEN_W'(LANE_N)) ? LEN_W'(LANE_N) : pat_len_r;

  // Handshake: a last item waits only for a free output register
  assign advance  = ir_vld_r && (!ir_last_r || !out_vld_r || out_ready);
  assign load_out = advance && ir_last_r;
  assign in_ready = !ir_vld_r || advance;

  always_comb begin
    ir_vld_nxt = ir_vld_r;
    if (in_valid && in_ready) begin
      ir_vld_nxt = 1'b1;
    end else if (advance) begin
      ir_vld_nxt = 1'b0;
    end
  end

  // Start offset: positions of one or below, negatives too, mean offset 0
  assign ofs_calc = (ir_start_r[POS_W-1] || (ir_start_r[OFS_W-1:0] <= OFS_W'(1))) ?
                    '0 : ir_start_r[OFS_W-1:0] - OFS_W'(1);

  // A first item clears the search before handling its own byte
  assign cnt_base       = ir_first_r ? '0 : cnt_r;
  assign ofs_nxt        = ir_first_r ? ofs_calc : ofs_r;
  assign found_base     = ir_first_r ? 1'b0 : found_r;
  assign found_idx_base = ir_first_r ? '0 : found_idx_r;
  assign ovf_base       = ir_first_r ? 1'b0 : ovf_r;

  // Drop bytes beyond the count limit and flag it
  assign at_lim  = (cnt_base == CNT_W'(HAY_MAX));
  assign take    = ir_present_r && !at_lim;
  assign cnt_nxt = cnt_base + CNT_W'(take);
  assign ovf_nxt = ovf_base || (ir_present_r && at_lim);

  // Shifted window; entries past the count are never compared, so no clearing
  always_comb begin
    win_nxt[0] = ir_byte_r;
    for (int j = 1; j < LANE_N; j++) begin
      win_nxt[j] = win_r[j-1];
    end
  end

  sfm_match #(
    .LANE_N (LANE_N)
  ) u_match (
    .win (win_nxt),
    .pat (pat_bytes),
    .len (eff_len),
    .hit (hit)
  );

  // Record the first match that starts at or after the offset
  assign match_ok = take && (eff_len != '0) && !found_base && hit &&
                    (CMP_W'(cnt_nxt) >= CMP_W'(eff_len) + CMP_W'(ofs_nxt));
  assign found_nxt     = found_base || match_ok;
  assign found_idx_nxt = match_ok ? (cnt_nxt - CNT_W'(eff_len) + CNT_W'(1)) : found_idx_base;

  // Result: empty pattern gives min(offset, count) + 1
  assign empty_idx = ((CMP_W'(ofs_nxt) < CMP_W'(cnt_nxt)) ? CMP_W'(ofs_nxt) : CMP_W'(cnt_nxt))
                     + CMP_W'(1);
  assign res_idx   = (eff_len == '0) ? empty_idx :
                     (found_nxt ? CMP_W'(found_idx_nxt) : '0);

  always_comb begin
    out_vld_nxt = out_vld_r;
    out_idx_nxt = out_idx_r;
    out_ovf_nxt = out_ovf_r;
    if (load_out) begin
      out_vld_nxt = 1'b1;
      out_idx_nxt = res_idx[IDX_W-1:0];
      out_ovf_nxt = ovf_nxt;
    end else if (out_ready) begin
      out_vld_nxt = 1'b0;
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ir_vld_r    <= 1'b0;
      out_vld_r   <= 1'b0;
      cnt_r       <= '0;
      ofs_r       <= '0;
      found_r     <= 1'b0;
      found_idx_r <= '0;
      ovf_r       <= 1'b0;
    end else begin
      ir_vld_r  <= ir_vld_nxt;
      out_vld_r <= out_vld_nxt;
      if (advance) begin
        cnt_r       <= cnt_nxt;
        ofs_r       <= ofs_nxt;
        found_r     <= found_nxt;
        found_idx_r <= found_idx_nxt;
        ovf_r       <= ovf_nxt;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      ir_byte_r    <= in_hay_byte;
      ir_present_r <= in_byte_present;
      ir_first_r   <= in_first_item;
      ir_last_r    <= in_last_item;
      ir_start_r   <= in_start_pos;
    end
    if (advance && take) begin
      win_r <= win_nxt;
    end
    out_idx_r <= out_idx_nxt;
    out_ovf_r <= out_ovf_nxt;
  end

  assign out_valid       = out_vld_r;
  assign out_match_index = out_idx_r;
  assign out_overflow    = out_ovf_r;

`ifndef NO_ASSERTIONS
  a_cnt_limit: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(HAY_MAX))
    else $error("byte count beyond limit");

  a_ovf_at_limit: assert property (@(posedge clk) disable iff (!rst_n)
    ovf_r |-> (cnt_r == CNT_W'(HAY_MAX)))
    else $error("overflow flagged below the count limit");

  a_found_idx: assert property (@(posedge clk) disable iff (!rst_n)
    found_r |-> ((found_idx_r != '0) && (found_idx_r <= cnt_r)))
    else $error("recorded match index outside counted bytes");

  a_last_held: assert property (@(posedge clk) disable iff (!rst_n)
    (ir_vld_r && ir_last_r && out_vld_r && !out_ready) |=> ir_vld_r)
    else $error("last item lost while result stalled");
`endif

endmodule

### test/substring_first_match_core_tb.sv
// Self-checking testbench for substring_first_match_core: directed and random haystacks
// are checked against a cycle-independent search predictor held in the bench.
// Depends on sfm_pkg and the substring_first_match_core RTL.
`timescale 1ns / 100ps

module substring_first_match_core_tb;
  import sfm_pkg::*;

  localparam int IDLE_GAP = 4;  // cycles allowed after the last result before a register write

  typedef struct packed {
    byte_t            hay_byte;
    logic             present;
    logic             first;
    logic             last;
    logic [POS_W-1:0] start_pos;
  } hay_item_t;

  typedef struct packed {
    logic [IDX_W-1:0] match_index;
    logic             overflow;
  } search_result_t;

  // DUT connections, all inputs driven to known values from time zero
  logic                    clk = 1'b0;
  logic                    rst_n = 1'b0;
  logic                    in_valid = 1'b0;
  logic                    in_ready;
  logic [7:0]              in_hay_byte = '0;
  logic                    in_byte_present = 1'b0;
  logic                    in_first_item = 1'b0;
  logic                    in_last_item = 1'b0;
  logic signed [POS_W-1:0] in_start_pos = '0;
  logic                    out_valid;
  logic                    out_ready = 1'b0;
  logic [IDX_W-1:0]        out_match_index;
  logic                    out_overflow;
  logic                    cfg_valid = 1'b0;
  logic                    cfg_ready;
  cfg_idx_t                cfg_index = CFG_PAT_LO;
  logic [CFG_DW-1:0]       cfg_data = '0;

  // Search mirror: registers and per-haystack state as the block should hold them
  logic [8*PAT_BYTES-1:0]  mirror_pattern = '0;
  logic [LEN_W-1:0]        mirror_len = '0;
  byte_t                   mirror_window [PATTERN_MAX_DEF];
  int                      mirror_count = 0;
  int                      mirror_offset = 0;
  bit                      mirror_found = 1'b0;
  int                      mirror_found_at = 0;
  bit                      mirror_overflow = 1'b0;

  search_result_t          pending_results [$];
  byte_t                   alpha [4] = '{8'h41, 8'h42, 8'h43, 8'h00};
  int                      snd_idle_pct = 0;
  int                      rcv_idle_pct = 0;
  int                      hold_request = 0;
  int                      hold_left = 0;
  int                      items_sent = 0;
  int                      error_count = 0;

  substring_first_match_core u_top (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_hay_byte     (in_hay_byte),
    .in_byte_present (in_byte_present),
    .in_first_item   (in_first_item),
    .in_last_item    (in_last_item),
    .in_start_pos    (in_start_pos),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_match_index (out_match_index),
    .out_overflow    (out_overflow),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  task automatic flag_error(input string msg);
    if (error_count < 40) begin
      $display("ERROR at %0t: %s", $time, msg);
    end
    error_count++;
  endtask

  function automatic int live_pattern_len();
    int n;
    n = mirror_len;
    if (n > 16) n = 16;
    if (n > PATTERN_MAX_DEF) n = PATTERN_MAX_DEF;
    return n;
  endfunction

  // Advance the mirror by one accepted transaction; queue a result on a last item
  function automatic void predict_search(input hay_item_t it);
    int n;
    int k;
    bit same;
    search_result_t res;
    if (it.first) begin
      for (k = 0; k < PATTERN_MAX_DEF; k++) mirror_window[k] = '0;
      mirror_count    = 0;
      mirror_found    = 1'b0;
      mirror_found_at = 0;
      mirror_overflow = 1'b0;
      if (it.start_pos[POS_W-1] || it.start_pos <= 1) begin
        mirror_offset = 0;
      end else begin
        mirror_offset = it.start_pos - 1;
      end
    end
    if (it.present) begin
      if (mirror_count >= HAY_MAX_DEF) begin
        mirror_overflow = 1'b1;
      end else begin
        for (k = PATTERN_MAX_DEF - 1; k > 0; k--) mirror_window[k] = mirror_window[k-1];
        mirror_window[0] = it.hay_byte;
        mirror_count++;
        n = live_pattern_len();
        if (n != 0 && !mirror_found && mirror_count >= n && mirror_count - n >= mirror_offset)
        begin
          same = 1'b1;
          for (k = 0; k < n; k++) begin
            if (mirror_pattern[8*k +: 8] != mirror_window[n-1-k]) same = 1'b0;
          end
          if (same) begin
            mirror_found    = 1'b1;
            mirror_found_at = mirror_count - n + 1;
          end
        end
      end
    end
    if (it.last) begin
      if (live_pattern_len() == 0) begin
        res.match_index =
          IDX_W'(((mirror_offset < mirror_count) ? mirror_offset : mirror_count) + 1);
      end else begin
        res.match_index = mirror_found ? IDX_W'(mirror_found_at) : '0;
      end
      res.overflow = mirror_overflow;
      pending_results.push_back(res);
    end
  endfunction

  function automatic hay_item_t make_item(input byte_t b, input logic present, input logic first,
                                          input logic last, input logic [POS_W-1:0] start);
    hay_item_t it;
    it.hay_byte  = b;
    it.present   = present;
    it.first     = first;
    it.last      = last;
    it.start_pos = start;
    return it;
  endfunction

  function automatic byte_t random_byte();
    if ($urandom_range(3) != 0) return alpha[$urandom_range(3)];
    return byte_t'($urandom_range(255));
  endfunction

  // Mostly small starts around the haystack, sometimes any 17-bit value
  function automatic logic [POS_W-1:0] random_start(input int n);
    int r;
    r = $urandom_range(99);
    if (r < 60) return POS_W'($urandom_range(0, 4));
    if (r < 85) return POS_W'($urandom_range(0, n + 2));
    return POS_W'($urandom);
  endfunction

  // Offer one transaction from a falling edge and hold it until accepted
  task automatic send_item(input hay_item_t it);
    while ($urandom_range(99) < snd_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid        <= 1'b1;
    in_hay_byte     <= it.hay_byte;
    in_byte_present <= it.present;
    in_first_item   <= it.first;
    in_last_item    <= it.last;
    in_start_pos    <= it.start_pos;
    do @(posedge clk); while (in_ready !== 1'b1);
    predict_search(it);
    items_sent++;
    @(negedge clk);
  endtask

  // Drop valid, wait for every result, then let the pipeline settle
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (IDLE_GAP) @(negedge clk);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [CFG_DW-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    case (idx)
      CFG_PAT_LO:  mirror_pattern[63:0]   = data;
      CFG_PAT_HI:  mirror_pattern[127:64] = data;
      CFG_PAT_LEN: mirror_len             = data[LEN_W-1:0];
      default: ;
    endcase
    @(negedge clk);
  endtask

  task automatic configure(input logic [CFG_DW-1:0] lo, input logic [CFG_DW-1:0] hi,
                           input logic [LEN_W-1:0] len);
    write_reg(CFG_PAT_LO, lo);
    write_reg(CFG_PAT_HI, hi);
    write_reg(CFG_PAT_LEN, {{(CFG_DW-LEN_W){1'b0}}, len});
    cfg_valid <= 1'b0;
  endtask

  // Pattern built mostly from the current alphabet so that matches are common
  task automatic pick_config();
    logic [8*PAT_BYTES-1:0] pat;
    logic [LEN_W-1:0] len;
    int r;
    int k;
    if ($urandom_range(1) == 1) begin
      for (k = 0; k < 4; k++) alpha[k] = byte_t'($urandom_range(255));
    end
    for (k = 0; k < PAT_BYTES; k++) begin
      pat[8*k +: 8] = ($urandom_range(9) == 0) ? byte_t'($urandom_range(255))
                                               : alpha[$urandom_range(3)];
    end
    if ($urandom_range(9) == 0) pat = {$urandom, $urandom, $urandom, $urandom};
    r = $urandom_range(99);
    if (r < 8) len = '0;
    else if (r < 16) len = 5'd16;
    else if (r < 24) len = LEN_W'($urandom_range(17, 31));
    else len = LEN_W'($urandom_range(1, 5));
    configure(pat[63:0], pat[127:64], len);
  endtask

  // One haystack, sometimes without a first item, sometimes with the pattern planted
  task automatic send_random_haystack();
    int n;
    int plant_at;
    int plen;
    int i;
    bit open_new;
    logic [POS_W-1:0] start;
    byte_t b;
    n        = ($urandom_range(9) == 0) ? $urandom_range(17, 60) : $urandom_range(0, 14);
    start    = random_start(n);
    open_new = ($urandom_range(19) != 0);
    plen     = live_pattern_len();
    plant_at = ($urandom_range(1) == 1 && n > 0) ? $urandom_range(0, n - 1) : -1;
    if (n == 0) send_item(make_item(byte_t'($urandom_range(255)), 1'b0, open_new, 1'b1, start));
    for (i = 0; i < n; i++) begin
      if (plant_at >= 0 && i >= plant_at && i < plant_at + plen) begin
        b = mirror_pattern[8*(i-plant_at) +: 8];
      end else begin
        b = random_byte();
      end
      send_item(make_item(b, $urandom_range(15) != 0, open_new && i == 0, i == n - 1,
                          (i == 0) ? start : POS_W'($urandom)));
    end
  endtask

  // Empty pattern: result is the clipped start offset plus one
  task automatic test_empty_pattern();
    wait_idle();
    configure('0, '0, '0);
    send_item(make_item(8'h00, 1'b0, 1'b1, 1'b1, 17'h10000));
    send_item(make_item(8'h5A, 1'b1, 1'b1, 1'b0, 17'h0FFFF));
    send_item(make_item(8'hA5, 1'b1, 1'b0, 1'b0, 17'h00000));
    send_item(make_item(8'hFF, 1'b0, 1'b0, 1'b0, 17'h1FFFF));
    send_item(make_item(8'h3C, 1'b1, 1'b0, 1'b1, 17'h00001));
  endtask

  // Byte extremes, negative start, continuation without a first item, start past a match
  task automatic test_match_extremes();
    wait_idle();
    configure(64'h0000_0000_0000_FF00, {CFG_DW{1'b1}}, 5'd2);
    send_item(make_item(8'hFF, 1'b1, 1'b1, 1'b0, 17'h1FFFF));
    send_item(make_item(8'h00, 1'b1, 1'b0, 1'b0, 17'h00000));
    send_item(make_item(8'hFF, 1'b1, 1'b0, 1'b1, 17'h00000));
    send_item(make_item(8'h00, 1'b0, 1'b0, 1'b1, 17'h0FFFF));
    send_item(make_item(8'h00, 1'b1, 1'b1, 1'b0, 17'd3));
    send_item(make_item(8'hFF, 1'b1, 1'b0, 1'b0, 17'd0));
    send_item(make_item(8'h00, 1'b1, 1'b0, 1'b0, 17'd0));
    send_item(make_item(8'hFF, 1'b1, 1'b0, 1'b1, 17'd0));
  endtask

  // Length above sixteen saturates; the full sixteen-byte window must match
  task automatic test_long_pattern();
    logic [CFG_DW-1:0] lo;
    logic [CFG_DW-1:0] hi;
    int k;
    lo = {$urandom, $urandom};
    hi = {$urandom, $urandom};
    wait_idle();
    configure(lo, hi, 5'd31);
    for (k = 0; k < PAT_BYTES; k++) begin
      send_item(make_item(mirror_pattern[8*k +: 8], 1'b1, k == 0, k == PAT_BYTES - 1, 17'd0));
    end
  endtask

  task automatic test_random_traffic(input int n_items);
    int target;
    target = items_sent + n_items;
    wait_idle();
    pick_config();
    while (items_sent < target) begin
      if ($urandom_range(5) == 0) begin
        wait_idle();
        pick_config();
      end
      send_random_haystack();
    end
  endtask

  // Rewrite the registers in the middle of an open haystack
  task automatic test_reconfig_midway();
    int round;
    int i;
    int n;
    for (round = 0; round < 6; round++) begin
      n = $urandom_range(1, 8);
      for (i = 0; i < n; i++) begin
        send_item(make_item(random_byte(), 1'b1, i == 0, 1'b0, random_start(n)));
      end
      wait_idle();
      pick_config();
      n = $urandom_range(1, 8);
      for (i = 0; i < n; i++) begin
        send_item(make_item(random_byte(), 1'b1, 1'b0, i == n - 1, POS_W'($urandom)));
      end
    end
  endtask

  // Hold the receiver off while short haystacks keep coming, then drain fully
  task automatic test_output_holdoff();
    int i;
    hold_request = 400;
    for (i = 0; i < 40; i++) begin
      send_item(make_item(random_byte(), 1'b1, 1'b1, 1'b0, random_start(2)));
      send_item(make_item(random_byte(), 1'($urandom_range(1)), 1'b0, 1'b1, POS_W'($urandom)));
    end
    wait_idle();
  endtask

  // Receiver: random back-pressure, or a counted hold-off when one is requested
  always @(negedge clk) begin
    if (hold_request > 0) begin
      hold_left    = hold_request;
      hold_request = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= rcv_idle_pct);
    end
  end

  // Compare each result transaction with the oldest expectation
  always @(posedge clk) begin : check_results
    search_result_t want;
    if (rst_n && out_valid === 1'b1 && out_ready === 1'b1) begin
      if (pending_results.size() == 0) begin
        flag_error($sformatf("result index %0d overflow %0b with none expected",
                             out_match_index, out_overflow));
      end else begin
        want = pending_results.pop_front();
        if (out_match_index !== want.match_index) begin
          flag_error($sformatf("match_index got %0d expected %0d",
                               out_match_index, want.match_index));
        end
        if (out_overflow !== want.overflow) begin
          flag_error($sformatf("overflow got %0b expected %0b", out_overflow, want.overflow));
        end
      end
    end
  end

  initial begin : main_sequence
    int wait_cycles;
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    snd_idle_pct = 10;
    rcv_idle_pct = 62;
    test_empty_pattern();
    test_match_extremes();
    test_long_pattern();
    test_random_traffic(160);
    test_reconfig_midway();
    test_output_holdoff();

    snd_idle_pct = 62;
    rcv_idle_pct = 10;
    test_random_traffic(160);

    snd_idle_pct = 0;
    rcv_idle_pct = 0;
    test_random_traffic(160);

    // Drain the remaining results, then allow the pipeline to settle
    in_valid <= 1'b0;
    for (wait_cycles = 0; wait_cycles < 5000 && pending_results.size() != 0; wait_cycles++) begin
      @(negedge clk);
    end
    if (pending_results.size() != 0) begin
      flag_error($sformatf("%0d results never arrived", pending_results.size()));
    end
    repeat (10) @(negedge clk);
    if (error_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

### substring_first_match_core.f
hdl/sfm_pkg.sv
hdl/sfm_match.sv
hdl/substring_first_match_core.sv
test/substring_first_match_core_tb.sv
